// ===== rtl/sdev_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - shared definitions
// Widths, constants and the entry type carried from front to back.
// ----------------------------------------------------------------------------
package sdev_pkg;

	localparam int unsigned GROUP_COUNT_DEF = 5;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned GROUP_W         = 3;
	localparam int unsigned NUMBER_W        = 5;
	localparam int unsigned CODE_W          = 9;
	localparam int unsigned COUNT_W         = 16;
	localparam int unsigned GROUP_MULT      = 100;
	localparam int unsigned BIT_IDX_W       = 3;

	typedef struct packed {
		logic [BYTE_W-1:0]  report_byte;
		logic [GROUP_W-1:0] group;
		logic               half;
	} q_entry_t;

	// Handshake between a producer and the entry queue
	typedef struct packed {
		logic     wr;
		q_entry_t entry;
	} q_push_t;

endpackage

// ===== rtl/sdev_front.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - front end
// Accepts report bytes, tags each with its group and half, advances position.
// ----------------------------------------------------------------------------
module sdev_front #(
	parameter int unsigned GROUP_COUNT = sdev_pkg::GROUP_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [sdev_pkg::BYTE_W-1:0]    report_byte,
	input  logic                           q_full,
	output sdev_pkg::q_push_t              q_push
);

	logic [sdev_pkg::GROUP_W-1:0] group_q;
	logic                         half_q;
	logic                         accept;
	logic [sdev_pkg::GROUP_W:0]   group_inc;

	assign accept    = push && !q_full;
	assign group_inc = {1'b0, group_q} + {{sdev_pkg::GROUP_W{1'b0}}, 1'b1};

	assign q_push.wr                = accept;
	assign q_push.entry.report_byte = report_byte;
	assign q_push.entry.group       = group_q;
	assign q_push.entry.half        = half_q;

	// Advance the position once per accepted byte; wrap after the last group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			half_q  <= 1'b0;
		end else if (accept) begin
			if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				if (group_inc >= (sdev_pkg::GROUP_W+1)'(GROUP_COUNT)) begin
					group_q <= '0;
				end else begin
					group_q <= group_inc[sdev_pkg::GROUP_W-1:0];
				end
			end
		end
	end

endmodule

// ===== rtl/sdev_queue.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - entry queue
// Two-entry register queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module sdev_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sdev_pkg::q_push_t   q_push,
	output logic                q_full,
	input  logic                rd,
	output logic                q_valid,
	output sdev_pkg::q_entry_t  head
);

	sdev_pkg::q_entry_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_rd;

	assign q_full  = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign head    = entry_q[rd_ptr_q];
	assign do_rd   = rd && q_valid;

	always_ff @(posedge clk) begin
		if (q_push.wr) begin
			entry_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (q_push.wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({q_push.wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/sdev_back.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - back end
// Scans one byte a bit per cycle unless a held event stalls it, drops repeats, counts and emits events.
// ----------------------------------------------------------------------------
module sdev_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  sdev_pkg::q_entry_t                head,
	output logic                              q_rd,
	input  logic                              pop,
	output logic                              empty,
	output logic [sdev_pkg::GROUP_W-1:0]      sensor_group,
	output logic [sdev_pkg::NUMBER_W-1:0]     sensor_number,
	output logic [sdev_pkg::CODE_W-1:0]       sensor_code,
	output logic [sdev_pkg::COUNT_W-1:0]      event_count,
	output logic                              last_of_run
);

	localparam int unsigned PROD_W = sdev_pkg::CODE_W + 1;

	logic [sdev_pkg::BYTE_W-1:0]   mask_q;
	logic [sdev_pkg::GROUP_W-1:0]  grp_q;
	logic                          half_q;
	logic [sdev_pkg::CODE_W-1:0]   last_code_q;
	logic [sdev_pkg::COUNT_W-1:0]  count_q;

	logic                          ovalid_q;
	logic [sdev_pkg::GROUP_W-1:0]  ogrp_q;
	logic [sdev_pkg::NUMBER_W-1:0] onum_q;
	logic [sdev_pkg::CODE_W-1:0]   ocode_q;
	logic [sdev_pkg::COUNT_W-1:0]  ocnt_q;
	logic                          olast_q;

	logic                          have;
	logic [sdev_pkg::BIT_IDX_W-1:0] hi_idx;
	logic [sdev_pkg::BYTE_W-1:0]   hi_bit;
	logic [sdev_pkg::BYTE_W-1:0]   rest;
	logic [sdev_pkg::NUMBER_W-1:0] number;
	logic [PROD_W-1:0]             code_full;
	logic [sdev_pkg::CODE_W-1:0]   code;
	logic                          dup;
	logic                          pop_ok;
	logic                          out_free;
	logic                          emit;
	logic                          step;
	logic [sdev_pkg::COUNT_W-1:0]  count_next;

	assign have = (mask_q != '0);

	// Highest set bit is the next sensor in report order
	always_comb begin
		hi_idx = '0;
		for (int i = 0; i < int'(sdev_pkg::BYTE_W); i++) begin
			if (mask_q[i]) begin
				hi_idx = sdev_pkg::BIT_IDX_W'(i);
			end
		end
	end

	assign hi_bit    = sdev_pkg::BYTE_W'(1) << hi_idx;
	assign rest      = mask_q & ~hi_bit;
	assign number    = {1'b0, half_q, ~hi_idx} + sdev_pkg::NUMBER_W'(1);
	assign code_full = PROD_W'(grp_q) * PROD_W'(sdev_pkg::GROUP_MULT)
	                 + PROD_W'(number);
	assign code      = code_full[sdev_pkg::CODE_W-1:0];
	assign dup       = (count_q != '0) && (code == last_code_q);

	assign pop_ok   = pop && ovalid_q;
	assign out_free = !ovalid_q || pop_ok;
	assign step     = have && (dup || out_free);
	assign emit     = have && !dup && out_free;
	assign q_rd     = !have && q_valid;

	assign count_next = (count_q == '1) ? count_q : count_q + sdev_pkg::COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			last_code_q <= '0;
			count_q     <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (q_rd) begin
				mask_q <= head.report_byte;
			end else if (step) begin
				mask_q <= rest;
			end
			if (emit) begin
				last_code_q <= code;
				count_q     <= count_next;
				ovalid_q    <= 1'b1;
			end else if (pop_ok) begin
				ovalid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			grp_q  <= head.group;
			half_q <= head.half;
		end
		if (emit) begin
			ogrp_q  <= grp_q;
			onum_q  <= number;
			ocode_q <= code;
			ocnt_q  <= count_next;
			// later bits of this byte can never repeat this code
			olast_q <= (rest == '0);
		end
	end

	assign empty         = !ovalid_q;
	assign sensor_group  = ogrp_q;
	assign sensor_number = onum_q;
	assign sensor_code   = ocode_q;
	assign event_count   = ocnt_q;
	assign last_of_run   = olast_q;

endmodule

// ===== rtl/sensor_dump_event_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - top level
// Turns sensor report bytes into a stream of deduplicated sensor events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive report_byte with push; a transaction completes on a
//   rising edge with push high and full low. Bytes follow the report order,
//   group A first half, group A second half, group B and so on, wrapping
//   after the last group.
//   Result channel: while empty is low the oldest event sits on the sensor_*,
//   event_count and last_of_run ports; pulse pop to take it. last_of_run
//   marks the final event caused by one byte.
//   Timing: a byte passes the queue, the back end's scan register and its
//   output register before its first event shows. The back end scans one
//   set bit per cycle while pop keeps up, and loads each byte as a separate
//   step before the scan; it takes no new byte until the last one is fully
//   scanned, so the bit scan sets the rate. A two-entry queue lets the front keep taking bytes meanwhile.
//   Stall: when pop stays low the event holds on the ports, the scan stops
//   at the next event and the queue fills, then full rises.
//   Reset: arst_n clears position to group A first half, empties the queue
//   and output, and forgets the last code and the event count.
// ----------------------------------------------------------------------------
module sensor_dump_event_decoder_unit #(
	parameter int unsigned GROUP_COUNT = sdev_pkg::GROUP_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sdev_pkg::BYTE_W-1:0]       report_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [sdev_pkg::GROUP_W-1:0]      sensor_group,
	output logic [sdev_pkg::NUMBER_W-1:0]     sensor_number,
	output logic [sdev_pkg::CODE_W-1:0]       sensor_code,
	output logic [sdev_pkg::COUNT_W-1:0]      event_count,
	output logic                              last_of_run
);

	sdev_pkg::q_push_t  q_push;
	sdev_pkg::q_entry_t q_head;
	logic               q_full;
	logic               q_valid;
	logic               q_rd;

	// Front: take bytes and tag them with their report position
	sdev_front #(
		.GROUP_COUNT(GROUP_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.report_byte(report_byte),
		.q_full     (q_full),
		.q_push     (q_push)
	);

	// Queue: hold tagged bytes until the back end drains them
	sdev_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.rd     (q_rd),
		.q_valid(q_valid),
		.head   (q_head)
	);

	// Back: scan bits, drop repeats, count and present events
	sdev_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (q_head),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.sensor_group (sensor_group),
		.sensor_number(sensor_number),
		.sensor_code  (sensor_code),
		.event_count  (event_count),
		.last_of_run  (last_of_run)
	);

	assign full = q_full;

endmodule

// ===== rtl/sdev_checker.sv =====
// ----------------------------------------------------------------------------
// Sensor dump event decoder - port checker
// Watches the top level ports for reset, stall and event consistency.
// ----------------------------------------------------------------------------
module sdev_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [sdev_pkg::GROUP_W-1:0]  sensor_group,
	input logic [sdev_pkg::NUMBER_W-1:0] sensor_number,
	input logic [sdev_pkg::CODE_W-1:0]   sensor_code,
	input logic [sdev_pkg::COUNT_W-1:0]  event_count
);

	logic [sdev_pkg::CODE_W:0] expect_code;

	assign expect_code = (sdev_pkg::CODE_W+1)'(sensor_group)
	                   * (sdev_pkg::CODE_W+1)'(sdev_pkg::GROUP_MULT)
	                   + (sdev_pkg::CODE_W+1)'(sensor_number);

	// No events and room for input while reset is held
	a_reset_clear: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("outputs not cleared in reset");

	// A waiting event holds until taken
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(sensor_code) && $stable(event_count))
		else $error("event changed while stalled");

	// Code is built from group and number
	a_code_form: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> sensor_code == expect_code[sdev_pkg::CODE_W-1:0])
		else $error("sensor code mismatch");

	// Number in range and every shown event counted
	a_number_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> sensor_number != '0 && sensor_number <= 5'd16 && event_count != '0)
		else $error("bad sensor number or event count");

endmodule

bind sensor_dump_event_decoder_unit sdev_checker u_sdev_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.sensor_group (sensor_group),
	.sensor_number(sensor_number),
	.sensor_code  (sensor_code),
	.event_count  (event_count)
);
